[hw/rtl/weighted_round_robin_three_queues_macros.svh]
// Assertion macros used by the weighted round-robin scheduler datapath.
`ifndef WEIGHTED_ROUND_ROBIN_THREE_QUEUES_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_THREE_QUEUES_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WRR3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WRR3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wrr3_pkg.sv]
// Shared types, codes and helper functions of the weighted round-robin scheduler.
package wrr3_pkg;

    localparam int CLASS_W  = 2;
    localparam int WEIGHT_W = 4;
    localparam int STATUS_W = 2;
    localparam int NUM_CLASSES = 3;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_HIGH = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_MID  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_LOW  = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_BAD  = 2'd3;

    localparam logic [1:0] CFG_HIGH_WEIGHT = 2'd0;
    localparam logic [1:0] CFG_MID_WEIGHT  = 2'd1;
    localparam logic [1:0] CFG_LOW_WEIGHT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    localparam logic [WEIGHT_W-1:0] RST_HIGH_WEIGHT = 4'd2;
    localparam logic [WEIGHT_W-1:0] RST_MID_WEIGHT  = 4'd1;
    localparam logic [WEIGHT_W-1:0] RST_LOW_WEIGHT  = 4'd1;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

    function automatic logic [CLASS_W-1:0] next_class(input logic [CLASS_W-1:0] c);
        logic [CLASS_W-1:0] r;
        case (c)
            CLS_HIGH: r = CLS_MID;
            CLS_MID:  r = CLS_LOW;
            default:  r = CLS_HIGH;
        endcase
        return r;
    endfunction

    function automatic logic [WEIGHT_W-1:0] eff_weight(input logic [WEIGHT_W-1:0] w);
        return (w == '0) ? WEIGHT_W'(1) : w;
    endfunction

endpackage

[hw/rtl/wrr3_ctrl.sv]
// Controller state machine sequencing capture, execution and delivery of one word.
module wrr3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output wrr3_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_DONE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);

endmodule

[hw/rtl/wrr3_dp.sv]
// Datapath with the queue memory, queue pointers, turn state and result registers.
`include "weighted_round_robin_three_queues_macros.svh"

module wrr3_dp #(
    parameter int QUEUE_DEPTH = 128,
    parameter int ID_WIDTH    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wrr3_pkg::t_dp_cmd              i_cmd,
    input  logic                           i_opcode,
    input  logic [wrr3_pkg::CLASS_W-1:0]   i_queue_class,
    input  logic [ID_WIDTH-1:0]            i_item_id,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [wrr3_pkg::WEIGHT_W-1:0]  i_cfg_data,
    output logic [wrr3_pkg::STATUS_W-1:0]  o_status,
    output logic [wrr3_pkg::CLASS_W-1:0]   o_served_class,
    output logic [ID_WIDTH-1:0]            o_served_id
);

    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = $clog2(3 * QUEUE_DEPTH);
    localparam int DEPTH = 3 * QUEUE_DEPTH;
    localparam logic [AW-1:0] OFF_MID = AW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] OFF_LOW = AW'(2 * QUEUE_DEPTH);

    logic                          r_op;
    logic [wrr3_pkg::CLASS_W-1:0]  r_cls;
    logic [ID_WIDTH-1:0]           r_id;

    logic [wrr3_pkg::WEIGHT_W-1:0] r_weight [0:2];
    logic [HW-1:0]                 r_head   [0:2];
    logic [HW-1:0]                 n_head   [0:2];
    logic [CW-1:0]                 r_count  [0:2];
    logic [CW-1:0]                 n_count  [0:2];
    logic [wrr3_pkg::CLASS_W-1:0]  r_turn;
    logic [wrr3_pkg::CLASS_W-1:0]  n_turn;
    logic [wrr3_pkg::WEIGHT_W-1:0] r_used;
    logic [wrr3_pkg::WEIGHT_W-1:0] n_used;

    logic [wrr3_pkg::STATUS_W-1:0] r_status;
    logic [wrr3_pkg::STATUS_W-1:0] n_status;
    logic [wrr3_pkg::CLASS_W-1:0]  r_srv_cls;
    logic [wrr3_pkg::CLASS_W-1:0]  n_srv_cls;
    logic                          r_served;

    logic [ID_WIDTH-1:0]           r_mem [0:DEPTH-1];
    logic [ID_WIDTH-1:0]           r_rd_data;

    logic [2:0]                    ne;
    logic                          any_ne;
    logic [wrr3_pkg::CLASS_W-1:0]  nxt1;
    logic [wrr3_pkg::CLASS_W-1:0]  nxt2;
    logic [wrr3_pkg::CLASS_W-1:0]  sel;
    logic [wrr3_pkg::WEIGHT_W-1:0] used_new;
    logic [wrr3_pkg::WEIGHT_W-1:0] w_turn;
    logic [wrr3_pkg::WEIGHT_W-1:0] w_sel;
    logic                          enq_ok;
    logic [CW:0]                   tail_sum;
    logic [HW-1:0]                 tail;
    logic [HW-1:0]                 ptr;
    logic [wrr3_pkg::CLASS_W-1:0]  mem_cls;
    logic [AW-1:0]                 mem_addr;
    logic                          mem_we;
    logic                          mem_re;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ne[k] = (r_count[k] != '0);
        end
        any_ne = |ne;
        nxt1   = wrr3_pkg::next_class(r_turn);
        nxt2   = wrr3_pkg::next_class(nxt1);
        w_turn = wrr3_pkg::eff_weight(r_weight[r_turn]);

        if (ne[r_turn] && (r_used < w_turn)) begin
            sel      = r_turn;
            used_new = r_used + 1'b1;
        end else if (ne[nxt1]) begin
            sel      = nxt1;
            used_new = wrr3_pkg::WEIGHT_W'(1);
        end else if (ne[nxt2]) begin
            sel      = nxt2;
            used_new = wrr3_pkg::WEIGHT_W'(1);
        end else begin
            sel      = r_turn;
            used_new = wrr3_pkg::WEIGHT_W'(1);
        end
        w_sel = wrr3_pkg::eff_weight(r_weight[sel]);

        enq_ok = (r_cls != wrr3_pkg::CLS_BAD) &&
                 (r_count[r_cls] != CW'(QUEUE_DEPTH));
        tail_sum = (CW + 1)'(r_head[r_cls]) + (CW + 1)'(r_count[r_cls]);
        if (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (CW + 1)'(QUEUE_DEPTH);
        end
        tail = tail_sum[HW-1:0];

        mem_cls = (r_op == wrr3_pkg::OP_SERVE) ? sel : r_cls;
        ptr     = (r_op == wrr3_pkg::OP_SERVE) ? r_head[sel] : tail;
        case (mem_cls)
            wrr3_pkg::CLS_MID: mem_addr = OFF_MID + AW'(ptr);
            wrr3_pkg::CLS_LOW: mem_addr = OFF_LOW + AW'(ptr);
            default:           mem_addr = AW'(ptr);
        endcase

        n_head    = r_head;
        n_count   = r_count;
        n_turn    = r_turn;
        n_used    = r_used;
        n_status  = r_status;
        n_srv_cls = r_srv_cls;
        mem_we    = 1'b0;
        mem_re    = 1'b0;

        if (i_cmd.exec) begin
            n_srv_cls = wrr3_pkg::CLS_HIGH;
            if (r_op == wrr3_pkg::OP_ENQUEUE) begin
                if (enq_ok) begin
                    mem_we          = 1'b1;
                    n_count[r_cls]  = r_count[r_cls] + 1'b1;
                    n_status        = wrr3_pkg::ST_ENQUEUED;
                end else begin
                    n_status = wrr3_pkg::ST_REJECTED;
                end
            end else if (!any_ne) begin
                n_status = wrr3_pkg::ST_EMPTY;
            end else begin
                mem_re       = 1'b1;
                n_status     = wrr3_pkg::ST_SERVED;
                n_srv_cls    = sel;
                n_count[sel] = r_count[sel] - 1'b1;
                n_head[sel]  = (r_head[sel] == HW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_head[sel] + 1'b1;
                if (used_new >= w_sel) begin
                    n_turn = wrr3_pkg::next_class(sel);
                    n_used = '0;
                end else begin
                    n_turn = sel;
                    n_used = used_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight[0] <= wrr3_pkg::RST_HIGH_WEIGHT;
            r_weight[1] <= wrr3_pkg::RST_MID_WEIGHT;
            r_weight[2] <= wrr3_pkg::RST_LOW_WEIGHT;
            for (int k = 0; k < 3; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
            r_turn   <= wrr3_pkg::CLS_HIGH;
            r_used   <= '0;
            r_served <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_turn  <= n_turn;
            r_used  <= n_used;
            if (i_cmd.exec) begin
                r_served <= mem_re;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wrr3_pkg::CFG_HIGH_WEIGHT: r_weight[0] <= i_cfg_data;
                    wrr3_pkg::CFG_MID_WEIGHT:  r_weight[1] <= i_cfg_data;
                    wrr3_pkg::CFG_LOW_WEIGHT:  r_weight[2] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_cls <= i_queue_class;
            r_id  <= i_item_id;
        end
        r_status  <= n_status;
        r_srv_cls <= n_srv_cls;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_id;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    assign o_status       = r_status;
    assign o_served_class = r_srv_cls;
    assign o_served_id    = r_served ? r_rd_data : '0;

    `WRR3_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        (r_count[0] <= CW'(QUEUE_DEPTH)) && (r_count[1] <= CW'(QUEUE_DEPTH)) &&
        (r_count[2] <= CW'(QUEUE_DEPTH)), "Queue count exceeds the queue depth.")
    `WRR3_ASSERT_NOW(a_turn_valid, i_clk, i_rst_n, 1'b1,
        r_turn != wrr3_pkg::CLS_BAD, "Turn points at a class that does not exist.")
    `WRR3_ASSERT_NEXT(a_serve_nonempty, i_clk, i_rst_n,
        i_cmd.exec && (r_op == wrr3_pkg::OP_SERVE) && any_ne,
        (r_status == wrr3_pkg::ST_SERVED) && r_served,
        "A serve with a waiting word did not deliver one.")
    `WRR3_ASSERT_NEXT(a_enqueue_counts, i_clk, i_rst_n,
        i_cmd.exec && (r_op == wrr3_pkg::OP_ENQUEUE) && enq_ok,
        (r_status == wrr3_pkg::ST_ENQUEUED) && !r_served,
        "An accepted enqueue did not report as enqueued.")

endmodule

[hw/rtl/weighted_round_robin_three_queues.sv]
// Top level of the weighted round-robin scheduler over three identifier queues.
//
// Usage: the input channel (i_in_valid, o_in_stall) carries a word holding an
// opcode, a queue class and an item id. An enqueue appends the id to its class
// queue or is rejected when the queue is full or the class is invalid. A serve
// removes one id if any queue holds one, following a high:medium:low weighted
// turn that skips empty classes. Every input word gives exactly one result word
// on the output channel (o_out_valid, i_out_stall) with a status, the served
// class and the served id. o_out_valid rises once the controller has moved from
// its capture state through its execute state into its deliver state around the
// single-port queue memory, and no new input word is taken until the result
// word has been taken. While the receiver stalls, the result word holds and no
// new word is taken. The weight registers are written through i_cfg_valid,
// i_cfg_index and i_cfg_data, and o_cfg_ready is always high. Reset empties
// all queues, sets the turn to the high class and the weights to 2, 1 and 1;
// the queue memory itself needs no clearing.
module weighted_round_robin_three_queues #(
    parameter int QUEUE_DEPTH = 128,
    parameter int ID_WIDTH    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [wrr3_pkg::CLASS_W-1:0]  i_queue_class,
    input  logic [ID_WIDTH-1:0]           i_item_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wrr3_pkg::STATUS_W-1:0] o_status,
    output logic [wrr3_pkg::CLASS_W-1:0]  o_served_class,
    output logic [ID_WIDTH-1:0]           o_served_id,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [wrr3_pkg::WEIGHT_W-1:0] i_cfg_data
);

    wrr3_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    wrr3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    wrr3_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_opcode),
        .i_queue_class  (i_queue_class),
        .i_item_id      (i_item_id),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (o_status),
        .o_served_class (o_served_class),
        .o_served_id    (o_served_id)
    );

endmodule

[tb/sv/tb_weighted_round_robin_three_queues.sv]
// Testbench for the weighted round-robin scheduler: directed table, random phases and a predictor.
module tb_weighted_round_robin_three_queues;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 128;
    localparam int ID_W = 16;
    localparam int FILL_LEN = 150;
    localparam int PHASE_LEN = 320;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_PAUSE = 8;
    localparam int IDLE_PCT = 29;
    localparam int NUM_PROBES = 18;
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [wrr3_pkg::STATUS_W-1:0] status;
        logic [wrr3_pkg::CLASS_W-1:0]  served_class;
        logic [ID_W-1:0]               served_id;
    } t_sched_result;

    typedef struct packed {
        logic                         op;
        logic [wrr3_pkg::CLASS_W-1:0] cls;
        logic [ID_W-1:0]              id;
        logic                         typed;
        t_sched_result                exp;
    } t_probe_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic opcode = wrr3_pkg::OP_ENQUEUE;
    logic [wrr3_pkg::CLASS_W-1:0] queue_class = wrr3_pkg::CLS_HIGH;
    logic [ID_W-1:0] item_id = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [1:0] cfg_index = wrr3_pkg::CFG_HIGH_WEIGHT;
    logic [wrr3_pkg::WEIGHT_W-1:0] cfg_data = '0;

    logic in_stall;
    logic out_valid;
    logic cfg_ready;
    logic [wrr3_pkg::STATUS_W-1:0] status;
    logic [wrr3_pkg::CLASS_W-1:0] served_class;
    logic [ID_W-1:0] served_id;

    logic [ID_W-1:0] q_store [wrr3_pkg::NUM_CLASSES][QUEUE_DEPTH];
    int q_head [wrr3_pkg::NUM_CLASSES];
    int q_count [wrr3_pkg::NUM_CLASSES];
    int turn_cls;
    int turn_used;
    logic [wrr3_pkg::WEIGHT_W-1:0] class_weight [wrr3_pkg::NUM_CLASSES];

    t_sched_result results_due [$];
    t_probe_row probes [NUM_PROBES];

    bit steady = 1'b0;
    bit held = 1'b0;
    int n_accepted = 0;
    int n_mismatch = 0;
    int n_settings = 1;
    int n_status [4] = '{0, 0, 0, 0};

    weighted_round_robin_three_queues #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_WIDTH(ID_W)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_opcode(opcode),
        .i_queue_class(queue_class),
        .i_item_id(item_id),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_status(status),
        .o_served_class(served_class),
        .o_served_id(served_id),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void pass_turn();
        turn_cls = (turn_cls >= wrr3_pkg::NUM_CLASSES - 1) ? 0 : turn_cls + 1;
        turn_used = 0;
    endfunction

    function automatic t_sched_result schedule_step(input logic op,
                                                    input logic [wrr3_pkg::CLASS_W-1:0] cls,
                                                    input logic [ID_W-1:0] id);
        t_sched_result r;
        int tail;
        int c;
        int w;
        r = '0;
        if (op == wrr3_pkg::OP_ENQUEUE) begin
            if (cls == wrr3_pkg::CLS_BAD || q_count[cls] >= QUEUE_DEPTH) begin
                r.status = wrr3_pkg::ST_REJECTED;
            end else begin
                tail = (q_head[cls] + q_count[cls]) % QUEUE_DEPTH;
                q_store[cls][tail] = id;
                q_count[cls]++;
                r.status = wrr3_pkg::ST_ENQUEUED;
            end
            return r;
        end
        r.status = wrr3_pkg::ST_EMPTY;
        if (q_count[0] == 0 && q_count[1] == 0 && q_count[2] == 0) begin
            return r;
        end
        for (int i = 0; i <= wrr3_pkg::NUM_CLASSES; i++) begin
            c = turn_cls;
            w = (class_weight[c] == '0) ? 1 : int'(class_weight[c]);
            if (q_count[c] > 0 && turn_used < w) begin
                r.status = wrr3_pkg::ST_SERVED;
                r.served_class = wrr3_pkg::CLASS_W'(c);
                r.served_id = q_store[c][q_head[c]];
                q_head[c] = (q_head[c] + 1) % QUEUE_DEPTH;
                q_count[c]--;
                turn_used++;
                if (turn_used >= w) begin
                    pass_turn();
                end
                return r;
            end
            pass_turn();
        end
        return r;
    endfunction

    task automatic send_word(input logic op, input logic [wrr3_pkg::CLASS_W-1:0] cls,
                             input logic [ID_W-1:0] id, input logic typed,
                             input t_sched_result exp);
        t_sched_result pred;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        queue_class <= cls;
        item_id <= id;
        do @(posedge clk); while (in_stall);
        pred = schedule_step(op, cls, id);
        results_due.push_back(typed ? exp : pred);
        n_accepted++;
    endtask

    task automatic drain_results();
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_weights(input logic [wrr3_pkg::WEIGHT_W-1:0] w_hi,
                                 input logic [wrr3_pkg::WEIGHT_W-1:0] w_mid,
                                 input logic [wrr3_pkg::WEIGHT_W-1:0] w_lo,
                                 input bit touch_unmapped);
        logic [1:0] idx [4];
        logic [wrr3_pkg::WEIGHT_W-1:0] val [4];
        int n;
        idx = '{wrr3_pkg::CFG_HIGH_WEIGHT, wrr3_pkg::CFG_MID_WEIGHT,
                wrr3_pkg::CFG_LOW_WEIGHT, CFG_UNMAPPED};
        val = '{w_hi, w_mid, w_lo, 4'hF};
        n = touch_unmapped ? 4 : 3;
        drain_results();
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            do @(posedge clk); while (!cfg_ready);
            if (idx[k] != CFG_UNMAPPED) begin
                class_weight[idx[k]] = val[k];
            end
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(input int n_items, input logic [wrr3_pkg::CLASS_W-1:0] fill_cls);
        int enq_pct;
        logic op;
        logic [wrr3_pkg::CLASS_W-1:0] cls;
        enq_pct = 95;
        for (int k = 0; k < n_items; k++) begin
            if (k >= FILL_LEN && (k - FILL_LEN) % 32 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 20;
                    1: enq_pct = 50;
                    default: enq_pct = 80;
                endcase
            end
            if (k < FILL_LEN && $urandom_range(9) != 0) begin
                cls = fill_cls;
            end else if ($urandom_range(15) == 0) begin
                cls = wrr3_pkg::CLS_BAD;
            end else begin
                cls = wrr3_pkg::CLASS_W'($urandom_range(2));
            end
            op = ($urandom_range(99) < enq_pct) ? wrr3_pkg::OP_ENQUEUE : wrr3_pkg::OP_SERVE;
            send_word(op, cls, ID_W'($urandom_range(16'hFFFF)), 1'b0, '0);
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        for (int c = 0; c < wrr3_pkg::NUM_CLASSES; c++) begin
            q_head[c] = 0;
            q_count[c] = 0;
        end
        turn_cls = 0;
        turn_used = 0;
        class_weight = '{wrr3_pkg::RST_HIGH_WEIGHT, wrr3_pkg::RST_MID_WEIGHT,
                         wrr3_pkg::RST_LOW_WEIGHT};
        probes = '{
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_HIGH, 16'h0000, 1'b1,
              '{wrr3_pkg::ST_EMPTY, wrr3_pkg::CLS_HIGH, 16'h0000}},
            '{wrr3_pkg::OP_ENQUEUE, wrr3_pkg::CLS_BAD, 16'hFFFF, 1'b1,
              '{wrr3_pkg::ST_REJECTED, wrr3_pkg::CLS_HIGH, 16'h0000}},
            '{wrr3_pkg::OP_ENQUEUE, wrr3_pkg::CLS_HIGH, 16'hFFFF, 1'b1,
              '{wrr3_pkg::ST_ENQUEUED, wrr3_pkg::CLS_HIGH, 16'h0000}},
            '{wrr3_pkg::OP_ENQUEUE, wrr3_pkg::CLS_HIGH, 16'h0000, 1'b1,
              '{wrr3_pkg::ST_ENQUEUED, wrr3_pkg::CLS_HIGH, 16'h0000}},
            '{wrr3_pkg::OP_ENQUEUE, wrr3_pkg::CLS_MID, 16'h8001, 1'b1,
              '{wrr3_pkg::ST_ENQUEUED, wrr3_pkg::CLS_HIGH, 16'h0000}},
            '{wrr3_pkg::OP_ENQUEUE, wrr3_pkg::CLS_LOW, 16'h7FFE, 1'b1,
              '{wrr3_pkg::ST_ENQUEUED, wrr3_pkg::CLS_HIGH, 16'h0000}},
            '{wrr3_pkg::OP_ENQUEUE, wrr3_pkg::CLS_HIGH, 16'h5A5A, 1'b0, '0},
            '{wrr3_pkg::OP_ENQUEUE, wrr3_pkg::CLS_MID, 16'hA5A5, 1'b0, '0},
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_BAD, 16'hFFFF, 1'b1,
              '{wrr3_pkg::ST_SERVED, wrr3_pkg::CLS_HIGH, 16'hFFFF}},
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_LOW, 16'h1234, 1'b0, '0},
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_HIGH, 16'h0000, 1'b0, '0},
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_MID, 16'hFFFF, 1'b0, '0},
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_HIGH, 16'h0F0F, 1'b0, '0},
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_HIGH, 16'h0000, 1'b0, '0},
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_BAD, 16'hFFFF, 1'b1,
              '{wrr3_pkg::ST_EMPTY, wrr3_pkg::CLS_HIGH, 16'h0000}},
            '{wrr3_pkg::OP_ENQUEUE, wrr3_pkg::CLS_LOW, 16'h0001, 1'b0, '0},
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_HIGH, 16'h0000, 1'b0, '0},
            '{wrr3_pkg::OP_SERVE, wrr3_pkg::CLS_LOW, 16'hC3C3, 1'b1,
              '{wrr3_pkg::ST_EMPTY, wrr3_pkg::CLS_HIGH, 16'h0000}}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < NUM_PROBES; k++) begin
            send_word(probes[k].op, probes[k].cls, probes[k].id, probes[k].typed, probes[k].exp);
        end
        run_random(PHASE_LEN, wrr3_pkg::CLS_HIGH);

        write_weights(4'd15, 4'd15, 4'd15, 1'b0);
        run_random(PHASE_LEN, wrr3_pkg::CLS_MID);

        write_weights(4'd1, 4'd1, 4'd1, 1'b0);
        steady = 1'b1;
        run_random(PHASE_LEN, wrr3_pkg::CLS_LOW);
        drain_results();
        steady = 1'b0;

        write_weights(4'd0, 4'd15, 4'd7, 1'b1);
        run_random(PHASE_LEN, wrr3_pkg::CLS_HIGH);

        write_weights(wrr3_pkg::WEIGHT_W'($urandom_range(15)),
                      wrr3_pkg::WEIGHT_W'($urandom_range(15)),
                      wrr3_pkg::WEIGHT_W'($urandom_range(15)), 1'b0);
        run_random(PHASE_LEN, wrr3_pkg::CLASS_W'($urandom_range(2)));

        drain_results();
        $display("Checked %0d results: %0d enqueued, %0d rejected, %0d served,",
                 n_accepted, n_status[wrr3_pkg::ST_ENQUEUED],
                 n_status[wrr3_pkg::ST_REJECTED], n_status[wrr3_pkg::ST_SERVED]);
        $display("%0d with nothing waiting, over %0d weight settings and a long output stall.",
                 n_status[wrr3_pkg::ST_EMPTY], n_settings);
        if (n_mismatch == 0 && results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        forever begin
            @(posedge clk);
            if (!held && n_accepted >= HOLD_AT) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        t_sched_result got;
        t_sched_result exp;
        if (rst_n && out_valid && !out_stall) begin
            got = '{status, served_class, served_id};
            if (results_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("Unexpected result word: status %0d class %0d id %h",
                             got.status, got.served_class, got.served_id);
                end
            end else begin
                exp = results_due.pop_front();
                n_status[got.status]++;
                if (got.status !== exp.status || got.served_class !== exp.served_class ||
                    got.served_id !== exp.served_id) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("Mismatch: expected status %0d class %0d id %h, got %0d %0d %h",
                                 exp.status, exp.served_class, exp.served_id,
                                 got.status, got.served_class, got.served_id);
                    end
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[weighted_round_robin_three_queues.f]
+incdir+hw/rtl
hw/rtl/wrr3_pkg.sv
hw/rtl/wrr3_ctrl.sv
hw/rtl/wrr3_dp.sv
hw/rtl/weighted_round_robin_three_queues.sv
tb/sv/tb_weighted_round_robin_three_queues.sv
